// File: design/sketch_spread_max_likelihood_core_assert.svh
// Assertion macros for the sketch spread estimator core.
// Used by the top level only; no other dependencies.
`ifndef SKETCH_SPREAD_MAX_LIKELIHOOD_CORE_ASSERT_SVH
`define SKETCH_SPREAD_MAX_LIKELIHOOD_CORE_ASSERT_SVH

`define SSML_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SSML_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/ssml_pkg.sv
// Types and constants for the sketch spread estimator.
// No dependencies.
package ssml_pkg;

  localparam int unsigned HALF_W = 32;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_SPREAD = 2'd1,
    CMD_VALUE  = 2'd2,
    CMD_COUNT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_CLEN = 2'd0,
    REG_SLEN = 2'd1,
    REG_MINV = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] table_index;
    logic [15:0] write_value;
    logic [63:0] flow_hash;
  } req_t;

  typedef struct packed {
    logic [9:0]  estimate;
    logic        found;
    logic [47:0] best_score;
  } rsp_t;

endpackage

// File: design/ssml_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ssml_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: design/sketch_spread_max_likelihood_core.sv
// Sketch spread maximum-likelihood estimator: top level.
// Depends on ssml_pkg, ssml_ram and the assertion macro header.
//
// A write request is done when it is accepted and does not raise busy. A
// query runs two 32-step restoring remainder passes, then counter reads in
// S_RD1, S_RD2 and S_WT. It then steps through S_CHK, S_RDP, S_MUL1, S_MUL2
// and S_CMP for each candidate: spread and value memory reads and a two-stage
// product. There are N = min(spread_table_len-1, H1, H2) candidates, fewer
// when the minimum value stops the scan; N is at most 255 since counters are
// 8 bits. A closing check in S_CHK and the output state S_OUT follow, and the
// result strobe is registered from S_OUT. The strobe lasts one cycle and the
// receiver cannot stall it. busy is high from query to result, and a new
// request is taken at the edge that ends the strobe cycle.
`include "sketch_spread_max_likelihood_core_assert.svh"
module sketch_spread_max_likelihood_core
  import ssml_pkg::*;
#(
  parameter int unsigned COUNTER_DEPTH = 4096,
  parameter int unsigned SPREAD_DEPTH  = 1024,
  parameter int unsigned VALUE_DEPTH   = 256,
  parameter int unsigned PROB_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  localparam int unsigned CW = $clog2(COUNTER_DEPTH);
  localparam int unsigned SW = $clog2(SPREAD_DEPTH);
  localparam int unsigned VW = $clog2(VALUE_DEPTH);
  localparam int unsigned PW = 3 * PROB_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV1, S_DIV2, S_RD1, S_RD2, S_WT, S_CHK, S_RDP, S_MUL1,
    S_MUL2, S_CMP, S_OUT
  } state_e;

  state_e state_q;
  logic [12:0] clen_q;
  logic [10:0] slen_q;
  logic [7:0]  minv_q;
  logic [HALF_W-1:0] num_q;
  logic [HALF_W-1:0] lo_q;
  logic [13:0] rem_q;
  logic [5:0]  bit_q;
  logic [12:0] clen_use;
  logic [13:0] rem_sh;
  logic [13:0] rem_sub;
  logic [13:0] rem_nx;
  logic [CW-1:0] pos1_q, pos2_q;
  logic [7:0]  h1_q, h2_q;
  logic [16:0] i_q;
  logic [10:0] slen_use;
  logic [2*PROB_BITS-1:0] m1_q;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] best_q;
  logic [16:0]   besti_q;
  logic [PROB_BITS-1:0] sp_rd, v1_rd, v2_rd;
  logic [7:0] cnt_rd;
  logic [8:0] d1, d2;
  logic v1_ok_q, v2_ok_q;

  logic        sp_we, v_we, c_we;
  logic [CW-1:0] c_raddr;
  logic [SW-1:0] sp_raddr;

  assign clen_use = (clen_q == 13'd0) ? 13'd1 :
                    ({19'd0, clen_q} > COUNTER_DEPTH) ? 13'(COUNTER_DEPTH) : clen_q;
  assign slen_use = ({21'd0, slen_q} > SPREAD_DEPTH) ? 11'(SPREAD_DEPTH) : slen_q;
  assign rem_sh  = {rem_q[12:0], num_q[HALF_W-1]};
  assign rem_sub = rem_sh - {1'b0, clen_use};
  assign rem_nx  = rem_sub[13] ? rem_sh : rem_sub;
  assign d1 = {1'b0, h1_q} - {1'b0, i_q[7:0]};
  assign d2 = {1'b0, h2_q} - {1'b0, i_q[7:0]};

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  logic acc;
  assign acc = start && !busy;
  assign sp_we = acc && req_i.command == CMD_SPREAD && {20'd0, req_i.table_index} < SPREAD_DEPTH;
  assign v_we  = acc && req_i.command == CMD_VALUE && {20'd0, req_i.table_index} < VALUE_DEPTH;
  assign c_we  = acc && req_i.command == CMD_COUNT &&
                 {20'd0, req_i.table_index} < COUNTER_DEPTH;
  assign c_raddr  = (state_q == S_RD1) ? pos1_q : pos2_q;
  assign sp_raddr = SW'(i_q);

  ssml_ram #(.Width(PROB_BITS), .Depth(SPREAD_DEPTH)) u_sp (
    .clk_i, .we_i(sp_we), .waddr_i(SW'(req_i.table_index)),
    .wdata_i(PROB_BITS'(req_i.write_value)), .raddr_i(sp_raddr), .rdata_o(sp_rd));
  ssml_ram #(.Width(PROB_BITS), .Depth(VALUE_DEPTH)) u_v1 (
    .clk_i, .we_i(v_we), .waddr_i(VW'(req_i.table_index)),
    .wdata_i(PROB_BITS'(req_i.write_value)), .raddr_i(VW'(d1)), .rdata_o(v1_rd));
  ssml_ram #(.Width(PROB_BITS), .Depth(VALUE_DEPTH)) u_v2 (
    .clk_i, .we_i(v_we), .waddr_i(VW'(req_i.table_index)),
    .wdata_i(PROB_BITS'(req_i.write_value)), .raddr_i(VW'(d2)), .rdata_o(v2_rd));
  ssml_ram #(.Width(8), .Depth(COUNTER_DEPTH)) u_cnt (
    .clk_i, .we_i(c_we), .waddr_i(CW'(req_i.table_index)),
    .wdata_i(req_i.write_value[7:0]), .raddr_i(c_raddr), .rdata_o(cnt_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clen_q <= 13'd4096;
      slen_q <= 11'd1024;
      minv_q <= 8'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CLEN: clen_q <= cfg_data_i;
        REG_SLEN: slen_q <= cfg_data_i[10:0];
        REG_MINV: minv_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o  <= 1'b0;
      num_q <= '0; lo_q <= '0; rem_q <= '0; bit_q <= '0; pos1_q <= '0; pos2_q <= '0;
      h1_q <= '0; h2_q <= '0; i_q <= '0; m1_q <= '0; prod_q <= '0;
      best_q <= '0; besti_q <= '0; rsp_o <= '0; v1_ok_q <= 1'b0; v2_ok_q <= 1'b0;
    end else begin
      done_o <= (state_q == S_OUT);
      unique case (state_q)
        S_IDLE: begin
          if (acc && req_i.command == CMD_QUERY) begin
            num_q   <= req_i.flow_hash[63:32];
            lo_q    <= req_i.flow_hash[31:0];
            rem_q   <= '0;
            bit_q   <= '0;
            state_q <= S_DIV1;
          end
        end
        S_DIV1, S_DIV2: begin
          if (bit_q == 6'(HALF_W - 1)) begin
            bit_q <= '0;
            if (state_q == S_DIV1) begin
              pos1_q  <= CW'(rem_nx);
              num_q   <= lo_q;
              rem_q   <= '0;
              state_q <= S_DIV2;
            end else begin
              pos2_q  <= CW'(rem_nx);
              state_q <= S_RD1;
            end
          end else begin
            rem_q <= rem_nx;
            num_q <= {num_q[HALF_W-2:0], 1'b0};
            bit_q <= bit_q + 6'd1;
          end
        end
        S_RD1: state_q <= S_RD2;
        S_RD2: begin
          h1_q <= cnt_rd;
          state_q <= S_WT;
        end
        S_WT: begin
          h2_q    <= cnt_rd;
          i_q     <= 17'd1;
          best_q  <= '0;
          besti_q <= '0;
          state_q <= S_CHK;
        end
        S_CHK: begin
          if ({6'd0, i_q[10:0]} >= {6'd0, slen_use} || i_q > {9'd0, h1_q} ||
              i_q > {9'd0, h2_q} || d1[7:0] < minv_q || d2[7:0] < minv_q) begin
            state_q <= S_OUT;
          end else begin
            v1_ok_q <= {23'd0, d1} < VALUE_DEPTH;
            v2_ok_q <= {23'd0, d2} < VALUE_DEPTH;
            state_q <= S_RDP;
          end
        end
        S_RDP: state_q <= S_MUL1;
        S_MUL1: begin
          m1_q <= sp_rd * (v1_ok_q ? v1_rd : '0);
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          prod_q <= m1_q * (v2_ok_q ? v2_rd : '0);
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (prod_q > best_q) begin
            best_q  <= prod_q;
            besti_q <= i_q;
          end
          i_q <= i_q + 17'd1;
          state_q <= S_CHK;
        end
        S_OUT: begin
          rsp_o.estimate   <= besti_q[9:0];
          rsp_o.found      <= best_q != '0;
          rsp_o.best_score <= 48'(best_q);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SSML_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  `SSML_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, state_q == S_IDLE)
  `SSML_ASSERT_IMPL(a_found_score, clk_i, rst_ni, done_o && !rsp_o.found,
                    rsp_o.best_score == '0 && rsp_o.estimate == '0)
endmodule
